// ===== design/mo_pkg.sv =====
// Shared types and constants for the multiplicative order block.
package mo_pkg;

   // Widths of the payload fields on the ports.
   localparam int unsigned FieldWidth  = 16;
   localparam int unsigned StatusWidth = 2;

   // Result status codes.
   localparam logic [StatusWidth-1:0] STATUS_FOUND    = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_MULTIPLE = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_NO_CYCLE = 2'd2;

   // Input beat.
   typedef struct packed {
      logic [FieldWidth-1:0] base_value;
      logic [FieldWidth-1:0] modulus;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [FieldWidth-1:0]  order;
      logic [StatusWidth-1:0] status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                   load;          // capture a new input beat
      logic                   start_reduce;  // begin base * 1 mod modulus
      logic                   start_power;   // begin power * residue mod modulus
      logic                   mul_step;      // one bit of the modular multiply
      logic                   take_residue;  // residue and power from product, k = 1
      logic                   take_power;    // power from product, k = k + 1
      logic                   out_load;      // write the result register
      logic [StatusWidth-1:0] out_status;    // status for the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mod_zero;   // modulus is zero
      logic last_step;  // current multiply step is the final bit
      logic acc_zero;   // product is zero
      logic k_over;     // step count has passed the modulus
      logic pw_one;     // running power equals one
   } stat_type;

endpackage

// ===== design/mo_dpath.sv =====
// Datapath: operand registers, bit-serial modular multiplier, step counter and result register.
module mo_dpath #(
   parameter int unsigned WIDTH = 16
) (
   input  logic             clock,
   input  mo_pkg::req_type  req_data,
   input  mo_pkg::cmd_type  cmd,
   output mo_pkg::stat_type stat,
   output mo_pkg::rsp_type  rsp_data
);

   localparam int unsigned CntWidth = $clog2(WIDTH);

   logic [WIDTH-1:0]    base_ff, base_in;
   logic [WIDTH-1:0]    mod_ff, mod_in;
   logic [WIDTH-1:0]    res_ff, res_in;
   logic [WIDTH-1:0]    pw_ff, pw_in;
   logic [WIDTH-1:0]    acc_ff, acc_in;
   logic [WIDTH-1:0]    mplr_ff, mplr_in;
   logic [WIDTH-1:0]    addend_ff, addend_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [WIDTH:0]      k_ff, k_in;
   mo_pkg::rsp_type     rsp_ff, rsp_in;

   logic [WIDTH:0] dbl;
   logic [WIDTH:0] dbl_red;
   logic [WIDTH:0] sum;
   logic [WIDTH:0] sum_red;
   logic [WIDTH:0] mod_ext;

   // One multiplier bit per cycle: double the product, then add the addend, reducing after each.
   always_comb begin
      mod_ext = {1'b0, mod_ff};
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
      sum     = dbl_red + (mplr_ff[WIDTH-1] ? {1'b0, addend_ff} : {(WIDTH+1){1'b0}});
      sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
   end

   // Next-state selection for the datapath registers.
   always_comb begin
      base_in   = base_ff;
      mod_in    = mod_ff;
      res_in    = res_ff;
      pw_in     = pw_ff;
      acc_in    = acc_ff;
      mplr_in   = mplr_ff;
      addend_in = addend_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      rsp_in    = rsp_ff;

      if (cmd.load) begin
         base_in = WIDTH'(req_data.base_value);
         mod_in  = WIDTH'(req_data.modulus);
      end

      // The base is reduced by multiplying it with one, which is zero when the modulus is one.
      if (cmd.start_reduce) begin
         acc_in    = '0;
         mplr_in   = base_ff;
         addend_in = (mod_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
         cnt_in    = CntWidth'(WIDTH - 1);
      end

      if (cmd.start_power) begin
         acc_in    = '0;
         mplr_in   = pw_ff;
         addend_in = res_ff;
         cnt_in    = CntWidth'(WIDTH - 1);
      end

      if (cmd.mul_step) begin
         acc_in  = sum_red[WIDTH-1:0];
         mplr_in = {mplr_ff[WIDTH-2:0], 1'b0};
         cnt_in  = cnt_ff - CntWidth'(1);
      end

      if (cmd.take_residue) begin
         res_in = acc_ff;
         pw_in  = acc_ff;
         k_in   = (WIDTH+1)'(1);
      end

      if (cmd.take_power) begin
         pw_in = acc_ff;
         k_in  = k_ff + (WIDTH+1)'(1);
      end

      // The order is reported only when one was found.
      if (cmd.out_load) begin
         rsp_in.status = cmd.out_status;
         rsp_in.order  = (cmd.out_status == mo_pkg::STATUS_FOUND) ?
                         mo_pkg::FieldWidth'(k_ff) : '0;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      mod_ff    <= mod_in;
      res_ff    <= res_in;
      pw_ff     <= pw_in;
      acc_ff    <= acc_in;
      mplr_ff   <= mplr_in;
      addend_ff <= addend_in;
      cnt_ff    <= cnt_in;
      k_ff      <= k_in;
      rsp_ff    <= rsp_in;
   end

   // Status back to the controller.
   always_comb begin
      stat.mod_zero  = (mod_ff == '0);
      stat.last_step = (cnt_ff == '0);
      stat.acc_zero  = (acc_ff == '0);
      stat.k_over    = (k_ff > {1'b0, mod_ff});
      stat.pw_one    = (pw_ff == WIDTH'(1));
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== design/mo_ctrl.sv =====
// Controller: state machine that sequences reduction, power iterations and result delivery.
module mo_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  mo_pkg::stat_type stat,
   output mo_pkg::cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_IDLE       = 8'b0000_0001,
      ST_SETUP      = 8'b0000_0010,
      ST_REDUCE     = 8'b0000_0100,
      ST_REDUCE_END = 8'b0000_1000,
      ST_CHECK      = 8'b0001_0000,
      ST_POWER      = 8'b0010_0000,
      ST_POWER_END  = 8'b0100_0000,
      ST_DONE       = 8'b1000_0000
   } state_type;

   state_type                         state_ff, state_in;
   logic [mo_pkg::StatusWidth-1:0]    fin_ff, fin_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // A new beat is taken only between items; a waiting result does not block it.
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequencing of one item.
   always_comb begin
      state_in     = state_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (stat.mod_zero) begin
               fin_in   = mo_pkg::STATUS_NO_CYCLE;
               state_in = ST_DONE;
            end else begin
               cmd.start_reduce = 1'b1;
               state_in         = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.mul_step = 1'b1;
            if (stat.last_step) begin
               state_in = ST_REDUCE_END;
            end
         end
         ST_REDUCE_END: begin
            if (stat.acc_zero) begin
               fin_in   = mo_pkg::STATUS_MULTIPLE;
               state_in = ST_DONE;
            end else begin
               cmd.take_residue = 1'b1;
               state_in         = ST_CHECK;
            end
         end
         // The order of a unit never exceeds the modulus, so a longer run has no cycle.
         ST_CHECK: begin
            if (stat.k_over) begin
               fin_in   = mo_pkg::STATUS_NO_CYCLE;
               state_in = ST_DONE;
            end else if (stat.pw_one) begin
               fin_in   = mo_pkg::STATUS_FOUND;
               state_in = ST_DONE;
            end else begin
               cmd.start_power = 1'b1;
               state_in        = ST_POWER;
            end
         end
         ST_POWER: begin
            cmd.mul_step = 1'b1;
            if (stat.last_step) begin
               state_in = ST_POWER_END;
            end
         end
         ST_POWER_END: begin
            cmd.take_power = 1'b1;
            state_in       = ST_CHECK;
         end
         // Wait until the result register is free or is being emptied.
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = fin_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Pending status needs no reset.
   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
   end

endmodule

// ===== design/multiplicative_order.sv =====
// Top level of the multiplicative order block: controller and datapath.
//
// Usage: an input beat on req_ carries a base and a modulus; one result beat on
// rsp_ carries the least k >= 1 with base^k = 1 mod modulus and a status (found,
// base a multiple of the modulus, or no cycle through one).
// One item is worked on at a time: req_stall is high from the cycle after a beat
// is taken until the result has been written to the output register.
// A single bit-serial modular multiplier first reduces the base, then runs once
// for each power step; an order of k takes k - 1 power steps before rsp_valid
// rises, and a base with no cycle runs modulus steps.
// A base that is a multiple of the modulus, or a zero modulus, returns early.
// The result sits in an output register, so a new beat is taken while a result
// waits on rsp_stall; a finished result that finds the register still full waits
// until it drains. A stalled result holds its payload.
// Reset is synchronous and clears the controller state and the output valid; no
// storage needs clearing, so the block takes a beat in the first cycle after it.
module multiplicative_order #(
   parameter int unsigned WIDTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  mo_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output mo_pkg::rsp_type rsp_data
);

   mo_pkg::cmd_type  cmd;
   mo_pkg::stat_type stat;

   // Sequencer.
   mo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Arithmetic and result register.
   mo_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the multiplicative order block.
`timescale 1ns / 100ps

module tb_top;

   // Cycles with no beat on either channel before the run is abandoned.
   localparam int unsigned StallLimit  = 200000;
   // Length of the long receiver hold-off that fills the block.
   localparam int unsigned HoldCycles  = 300;
   // Cycles allowed after the last expected result for any stray beat.
   localparam int unsigned TrailCycles = 60;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   mo_pkg::req_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   mo_pkg::rsp_type rsp_data;

   // Results still owed by the block, oldest first.
   mo_pkg::rsp_type pending_orders[$];
   int unsigned     mismatches = 0;
   int unsigned     quiet_cycles = 0;

   // Idling controls shared by the stimulus and the receiver process.
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   int unsigned hold_len = 0;
   // Shadow of req_valid, so that it is only lowered once per step.
   bit          req_up = 1'b0;

   multiplicative_order dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Least k >= 1 with base^k = 1 mod modulus, bounded by the modulus.
   function automatic mo_pkg::rsp_type predict_order(input mo_pkg::req_type item);
      mo_pkg::rsp_type res;
      logic [31:0]     b, m, r, pw, k;
      res.order  = '0;
      res.status = mo_pkg::STATUS_NO_CYCLE;
      b = 32'(item.base_value);
      m = 32'(item.modulus);
      if (m == 0) return res;
      r = b % m;
      if (r == 0) begin
         res.status = mo_pkg::STATUS_MULTIPLE;
         return res;
      end
      pw = r;
      for (k = 1; k <= m; k++) begin
         if (pw == 1) begin
            res.order  = k[15:0];
            res.status = mo_pkg::STATUS_FOUND;
            return res;
         end
         pw = (pw * r) % m;
      end
      return res;
   endfunction

   function automatic mo_pkg::req_type make_item(input logic [15:0] b, input logic [15:0] m);
      mo_pkg::req_type item;
      item.base_value = b;
      item.modulus    = m;
      return item;
   endfunction

   // Mostly small moduli with any base; large moduli only with bases whose
   // residue is 0, 1 or -1, so that the work per beat stays short.
   function automatic mo_pkg::req_type random_item();
      mo_pkg::req_type item;
      int unsigned     m, j, offset, pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         m = $urandom_range(1, 255);
         item.base_value = 16'($urandom);
      end else if (pick < 7) begin
         m = $urandom_range(256, 1024);
         item.base_value = 16'($urandom);
      end else begin
         m = $urandom_range(1025, 65535);
         case ($urandom_range(0, 2))
            0: begin
               offset = 0;
            end
            1: begin
               offset = 1;
            end
            default: begin
               offset = m - 1;
            end
         endcase
         j = $urandom_range(0, (65535 - offset) / m);
         item.base_value = 16'(j * m + offset);
      end
      item.modulus = 16'(m);
      return item;
   endfunction

   // Offer one beat, wait for it to be taken, then perhaps idle a while.
   task automatic send_item(input mo_pkg::req_type item);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= item;
      req_up     = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_orders.push_back(predict_order(item));
      gap = 0;
      if (req_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_up     = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering beats and wait until every owed result has arrived.
   task automatic drain_results();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up     = 1'b0;
      end
      while (pending_orders.size() != 0) @(posedge clock);
   endtask

   // Extremes of the fields and each special case in turn.
   task automatic test_special_cases();
      send_item(make_item(16'd0, 16'd1));          // modulus one
      send_item(make_item(16'hFFFF, 16'd1));
      send_item(make_item(16'd0, 16'hFFFF));       // base zero
      send_item(make_item(16'hFFFF, 16'hFFFF));    // base equal to the modulus
      send_item(make_item(16'd12, 16'd6));         // base a multiple of the modulus
      send_item(make_item(16'd5, 16'd0));          // modulus zero
      send_item(make_item(16'hFFFF, 16'd0));
      send_item(make_item(16'd1, 16'd2));
      send_item(make_item(16'd3, 16'd2));
      send_item(make_item(16'd2, 16'd4));          // shares a factor, no cycle
      send_item(make_item(16'd6, 16'd9));
      send_item(make_item(16'd2, 16'd1024));
      send_item(make_item(16'd2, 16'd7));
      send_item(make_item(16'd3, 16'd7));          // primitive root
      send_item(make_item(16'd2, 16'd1019));       // long order under a prime
      send_item(make_item(16'hFFFE, 16'hFFFF));    // residue minus one
      send_item(make_item(16'hFFFF, 16'hFFFE));    // residue one
      send_item(make_item(16'hFFFF, 16'h8000));
      send_item(make_item(16'h8001, 16'h8000));
      send_item(make_item(16'h5555, 16'h2AAA));
   endtask

   // The receiver holds off long enough for the block to fill and stall.
   task automatic test_output_backpressure();
      bit saved_idle;
      saved_idle  = req_idle_on;
      req_idle_on = 1'b0;
      hold_len    = HoldCycles;
      repeat (6) send_item(make_item(16'd1, 16'($urandom_range(2, 65535))));
      req_idle_on = saved_idle;
   endtask

   task automatic test_random_traffic(input int unsigned count);
      repeat (count) send_item(random_item());
   endtask

   // The sender goes quiet until the block has returned everything.
   task automatic test_sender_pause();
      drain_results();
      repeat (3) send_item(random_item());
   endtask

   // Receiver stall bursts, and the long hold-off on request.
   initial begin : rsp_stall_gen
      int unsigned burst;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            burst    = hold_len;
            hold_len = 0;
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each result beat with the oldest owed result.
   always @(posedge clock) begin : result_check
      mo_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_orders.size() == 0) begin
            $display("%0t: unexpected result beat order=%0d status=%0d",
                     $time, rsp_data.order, rsp_data.status);
            mismatches++;
         end else begin
            want = pending_orders.pop_front();
            if (rsp_data.order !== want.order) begin
               $display("%0t: order mismatch, expected %0d, actual %0d",
                        $time, want.order, rsp_data.order);
               mismatches++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_data.status);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
         $display("%0t: timeout, %0d results outstanding", $time, pending_orders.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_cases();
      test_output_backpressure();
      test_random_traffic(41);
      test_sender_pause();
      // Final stretch at full rate on both sides.
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_random_traffic(30);
      drain_results();
      repeat (TrailCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
